// ===== design/udsd_pkg.sv =====
// shared types and constants of the unary delta sample decoder
package udsd_pkg;

	// word classes found by the front end
	localparam logic [1:0] KIND_EMPTY  = 2'd0;
	localparam logic [1:0] KIND_RAW    = 2'd1;
	localparam logic [1:0] KIND_PACKED = 2'd2;
	localparam logic [1:0] KIND_BAD    = 2'd3;

	localparam int WORD_W    = 16;
	localparam int SAMPLE_W  = 12;
	localparam int STREAM_W  = 15;
	localparam int ZCNT_W    = 4;
	localparam logic [ZCNT_W-1:0] MAX_ZEROS = 4'd6;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'hfff;

	// one classified word as held in the queue
	typedef struct packed {
		logic [1:0]          kind;
		logic                first;
		logic [STREAM_W-1:0] data;
	} udsd_entry_t;

endpackage

// ===== design/udsd_front.sv =====
// front end: classifies a word and strips the packed-word marker
module udsd_front (
	input  logic [15:0]          code_word,
	input  logic                 first_of_channel,
	output udsd_pkg::udsd_entry_t entry
);

	logic [3:0]  marker;
	logic [4:0]  shamt;
	logic [15:0] shifted;

	// lowest set bit among bits 0..14
	always_comb begin
		marker = 4'd0;
		for (int i = udsd_pkg::STREAM_W - 1; i >= 0; i--) begin
			if (code_word[i]) begin
				marker = 4'(i);
			end
		end
	end

	// code stream above the marker, closing one at the top
	assign shamt   = {1'b0, marker} + 5'd1;
	assign shifted = code_word >> shamt;

	// classification
	always_comb begin
		entry.first = first_of_channel;
		if (code_word[15:12] == 4'd0) begin
			entry.kind = udsd_pkg::KIND_RAW;
			entry.data = code_word[udsd_pkg::STREAM_W-1:0];
		end else if (!code_word[15]) begin
			entry.kind = udsd_pkg::KIND_BAD;
			entry.data = '0;
		end else if (code_word[14:0] == 15'd0) begin
			entry.kind = udsd_pkg::KIND_EMPTY;
			entry.data = '0;
		end else begin
			entry.kind = udsd_pkg::KIND_PACKED;
			entry.data = shifted[udsd_pkg::STREAM_W-1:0];
		end
	end

endmodule

// ===== design/udsd_queue.sv =====
// small register queue between front and back end
module udsd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  udsd_pkg::udsd_entry_t wr_data,
	output logic                  rd_valid,
	input  logic                  rd_ready,
	output udsd_pkg::udsd_entry_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	udsd_pkg::udsd_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic wr_fire, rd_fire;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];
	assign wr_fire  = wr_valid && wr_ready;
	assign rd_fire  = rd_valid && rd_ready;

	// storage
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_fire) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd_fire) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/udsd_back.sv =====
// back end: code sequencer, sample state and output register
module udsd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  udsd_pkg::udsd_entry_t q_data,
	output logic [11:0]           sample_value,
	output logic                  decode_error,
	output logic                  last_of_word,
	output logic                  out_valid,
	input  logic                  out_ready
);

	logic [udsd_pkg::SAMPLE_W-1:0] prev_q, prev_d, eff_prev;
	logic halted_q, halted_d, eff_halt;
	logic busy_q, busy_d;
	logic [udsd_pkg::STREAM_W-1:0] cur_q, cur_d, cur_next;
	logic out_valid_q, err_q, last_q;
	logic [udsd_pkg::SAMPLE_W-1:0] sample_q;
	logic emit, emit_err, emit_last;
	logic [udsd_pkg::SAMPLE_W-1:0] emit_sample, new_sample;
	logic slot_free, pop;
	logic [udsd_pkg::ZCNT_W-1:0] tz;
	logic [4:0] shamt;
	logic [2:0] mag;
	logic signed [13:0] sum;

	assign slot_free = !out_valid_q || out_ready;
	assign q_ready   = !busy_q && slot_free;
	assign pop       = q_valid && q_ready;

	// zero count of the next code
	always_comb begin
		tz = '0;
		for (int i = udsd_pkg::STREAM_W - 1; i >= 0; i--) begin
			if (cur_q[i]) begin
				tz = udsd_pkg::ZCNT_W'(i);
			end
		end
	end

	assign shamt    = {1'b0, tz} + 5'd1;
	assign cur_next = cur_q >> shamt;

	// difference applied to the previous sample, clamped
	assign mag = 3'((tz + 4'd1) >> 1);
	always_comb begin
		if (tz[0]) begin
			sum = $signed({2'b00, prev_q}) - $signed({11'd0, mag});
		end else begin
			sum = $signed({2'b00, prev_q}) + $signed({11'd0, mag});
		end
		if (sum < 0) begin
			new_sample = '0;
		end else if (sum > $signed({2'b00, udsd_pkg::SAMPLE_MAX})) begin
			new_sample = udsd_pkg::SAMPLE_MAX;
		end else begin
			new_sample = sum[udsd_pkg::SAMPLE_W-1:0];
		end
	end

	// sequencer
	always_comb begin
		prev_d      = prev_q;
		halted_d    = halted_q;
		busy_d      = busy_q;
		cur_d       = cur_q;
		emit        = 1'b0;
		emit_err    = 1'b0;
		emit_last   = 1'b1;
		emit_sample = '0;
		eff_prev    = q_data.first ? '0 : prev_q;
		eff_halt    = q_data.first ? 1'b0 : halted_q;
		if (pop) begin
			prev_d   = eff_prev;
			halted_d = eff_halt;
			if (!eff_halt) begin
				case (q_data.kind)
					udsd_pkg::KIND_RAW: begin
						emit        = 1'b1;
						emit_sample = q_data.data[udsd_pkg::SAMPLE_W-1:0];
						prev_d      = q_data.data[udsd_pkg::SAMPLE_W-1:0];
					end
					udsd_pkg::KIND_BAD: begin
						emit     = 1'b1;
						emit_err = 1'b1;
						halted_d = 1'b1;
					end
					udsd_pkg::KIND_PACKED: begin
						busy_d = 1'b1;
						cur_d  = q_data.data;
					end
					default: begin
					end
				endcase
			end
		end else if (busy_q && slot_free) begin
			emit = 1'b1;
			if (tz > udsd_pkg::MAX_ZEROS) begin
				emit_err = 1'b1;
				halted_d = 1'b1;
				busy_d   = 1'b0;
			end else begin
				emit_sample = new_sample;
				prev_d      = new_sample;
				emit_last   = (cur_next == '0);
				busy_d      = (cur_next != '0);
				cur_d       = cur_next;
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			halted_q    <= 1'b0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			prev_q   <= prev_d;
			halted_q <= halted_d;
			busy_q   <= busy_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// code stream and output payload
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (emit) begin
			sample_q <= emit_sample;
			err_q    <= emit_err;
			last_q   <= emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = sample_q;
	assign decode_error = err_q;
	assign last_of_word = last_q;

	// a code stream in progress always holds its closing one
	a_busy_stream: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_q != '0))
		else $error("code stream empty while busy");

	// a halted decoder has no word in progress
	a_busy_halt: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !halted_q)
		else $error("busy while halted");

	// a pending error result leaves the decoder halted
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> halted_q)
		else $error("error result without halt");

	// an error result is final and carries no sample
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q) |-> (last_q && sample_q == '0))
		else $error("malformed error result");

endmodule

// ===== design/unary_delta_sample_decoder_top.sv =====
// top level of the unary delta sample decoder
// Decodes one channel of 16-bit words into 12-bit samples. The front end
// classifies each word on acceptance and writes it into a QUEUE_DEPTH-entry
// queue, so input is taken every cycle while the queue has room. The back
// end takes a raw or malformed word straight into the output register; a packed
// word is loaded into the code sequencer, which retires one code per cycle into
// the output register while that register is free, for up to 15 samples, and
// takes no new word until its codes are done. Words that yield no result
// still pass the back end. A halt after an error lasts until a word flagged
// as the first of a channel.
module unary_delta_sample_decoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] code_word,
	input  logic        first_of_channel,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [11:0] sample_value,
	output logic        decode_error,
	output logic        last_of_word,
	output logic        out_valid,
	input  logic        out_ready
);

	udsd_pkg::udsd_entry_t front_entry, back_entry;
	logic q_valid, q_ready;

	// classify incoming words
	udsd_front u_front (
		.code_word        (code_word),
		.first_of_channel (first_of_channel),
		.entry            (front_entry)
	);

	// decouple front and back end
	udsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_ready (in_ready),
		.wr_data  (front_entry),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_data  (back_entry)
	);

	// decode and emit samples
	udsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_data       (back_entry),
		.sample_value (sample_value),
		.decode_error (decode_error),
		.last_of_word (last_of_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule

// ===== dv/tb_unary_delta_sample_decoder_top.sv =====
// testbench of the unary delta sample decoder: directed and random words checked against a predictor
module tb_unary_delta_sample_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 360;
	localparam int CYCLE_LIMIT  = 400_000;
	localparam int TAIL_CYCLES  = 64;

	// one decoded result as seen on the output ports
	typedef struct packed {
		logic [udsd_pkg::SAMPLE_W-1:0] sample;
		logic                          error;
		logic                          last;
	} decoded_t;

	// predicts decoded samples per accepted word and checks the output stream
	class decode_scoreboard;
		logic [udsd_pkg::SAMPLE_W-1:0] prev_sample = '0;
		bit                            halted = 1'b0;
		decoded_t                      expected_samples[$];
		int                            mismatches = 0;

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		// append one expected result at the tail
		function void queue_expected(decoded_t r);
			expected_samples.insert(expected_samples.size(), r);
		endfunction

		// step to the next sample: zero count selects 0,-1,+1,-2,+2,-3,+3
		function logic [udsd_pkg::SAMPLE_W-1:0] step_sample(int zeros);
			int mag;
			int sum;
			mag = (zeros + 1) >> 1;
			sum = int'(prev_sample) + ((zeros % 2) ? -mag : mag);
			if (sum < 0)
				sum = 0;
			if (sum > int'(udsd_pkg::SAMPLE_MAX))
				sum = int'(udsd_pkg::SAMPLE_MAX);
			return sum[udsd_pkg::SAMPLE_W-1:0];
		endfunction

		// note an accepted input transaction and queue what it decodes to
		function void predict_word(logic [udsd_pkg::WORD_W-1:0] w, logic first);
			int  zeros;
			int  produced;
			bit  found;
			bit  bad;
			decoded_t r;
			zeros = 0;
			produced = 0;
			found = 1'b0;
			bad = 1'b0;
			if (first) begin
				prev_sample = '0;
				halted = 1'b0;
			end
			if (halted)
				return;
			// raw sample
			if (w[15:12] == 4'h0) begin
				prev_sample = w[udsd_pkg::SAMPLE_W-1:0];
				r = '{sample: prev_sample, error: 1'b0, last: 1'b1};
				queue_expected(r);
				return;
			end
			if (!w[15]) begin
				bad = 1'b1;
			end else begin
				// marker first, then one code per later one bit
				for (int i = 0; i < udsd_pkg::WORD_W; i++) begin
					if (!found) begin
						if (i < 15 && w[i])
							found = 1'b1;
						continue;
					end
					if (!w[i]) begin
						zeros++;
						continue;
					end
					if (zeros > int'(udsd_pkg::MAX_ZEROS)) begin
						bad = 1'b1;
						break;
					end
					prev_sample = step_sample(zeros);
					r = '{sample: prev_sample, error: 1'b0, last: 1'b0};
					queue_expected(r);
					produced++;
					zeros = 0;
				end
			end
			if (bad) begin
				r = '{sample: '0, error: 1'b1, last: 1'b0};
				queue_expected(r);
				produced++;
				halted = 1'b1;
			end
			if (produced > 0)
				expected_samples[expected_samples.size() - 1].last = 1'b1;
		endfunction

		// compare one output transaction with the oldest expectation
		task check_sample(logic [udsd_pkg::SAMPLE_W-1:0] s, logic e, logic l);
			decoded_t exp_r;
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected result sample=%0d error=%0b last=%0b",
					s, e, l));
				return;
			end
			exp_r = expected_samples.pop_front();
			if (s !== exp_r.sample)
				report_mismatch($sformatf("sample_value %0d, wanted %0d", s, exp_r.sample));
			if (e !== exp_r.error)
				report_mismatch($sformatf("decode_error %0b, wanted %0b", e, exp_r.error));
			if (l !== exp_r.last)
				report_mismatch($sformatf("last_of_word %0b, wanted %0b", l, exp_r.last));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic [udsd_pkg::WORD_W-1:0]   code_word;
	logic                          first_of_channel;
	logic                          in_valid;
	logic                          in_ready;
	logic [udsd_pkg::SAMPLE_W-1:0] sample_value;
	logic                          decode_error;
	logic                          last_of_word;
	logic                          out_valid;
	logic                          out_ready;

	decode_scoreboard board = new;
	bit               draining = 1'b0;
	int               burst_left = 0;
	int               cycle_count = 0;

	unary_delta_sample_decoder_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.code_word       (code_word),
		.first_of_channel(first_of_channel),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_value    (sample_value),
		.decode_error    (decode_error),
		.last_of_word    (last_of_word),
		.out_valid       (out_valid),
		.out_ready       (out_ready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_unary_delta_sample_decoder_top NOT OK");
		$finish;
	end

	// present one word and hold it until the transaction completes
	task automatic send_word(logic [udsd_pkg::WORD_W-1:0] w, logic first);
		@(negedge clk);
		code_word = w;
		first_of_channel = first;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
		board.predict_word(w, first);
	endtask

	// bursts of random length with random gaps, some of them gapless
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	// hold off input until every queued sample has come out
	task automatic wait_all_decoded();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.expected_samples.size() != 0)
			@(negedge clk);
	endtask

	// well-formed packed word, or one with an overlong code
	function automatic logic [udsd_pkg::WORD_W-1:0] packed_word(bit with_bad);
		logic [udsd_pkg::WORD_W-1:0] w;
		int                          pos;
		int                          left;
		int                          z;
		w = '0;
		pos = $urandom_range(0, with_bad ? 7 : 14);
		w[pos] = 1'b1;
		left = 15 - pos;
		while (left > 0) begin
			pos = 15 - left;
			if (with_bad && (left < 9 || $urandom_range(0, 2) == 0)) begin
				z = $urandom_range(7, left - 1);
				w[pos + z + 1] = 1'b1;
				for (int i = pos + z + 2; i < udsd_pkg::WORD_W; i++)
					w[i] = 1'($urandom_range(0, 1));
				w[15] = 1'b1;
				left = 0;
			end else begin
				z = $urandom_range(0, with_bad ? ((left - 9 < 6) ? left - 9 : 6)
					: ((left - 1 < 6) ? left - 1 : 6));
				w[pos + z + 1] = 1'b1;
				left -= z + 1;
			end
		end
		return w;
	endfunction

	// random word mix: mostly raw and well-formed packed, some malformed and noise
	function automatic logic [udsd_pkg::WORD_W-1:0] pick_word();
		int sel;
		int range_sel;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			range_sel = $urandom_range(0, 2);
			if (range_sel == 0)
				return {4'h0, 12'($urandom_range(0, 7))};
			else if (range_sel == 1)
				return {4'h0, 12'($urandom_range(4088, 4095))};
			return {4'h0, 12'($urandom)};
		end
		if (sel < 80)
			return packed_word(1'b0);
		if (sel < 87)
			return packed_word(1'b1);
		if (sel < 92)
			return {1'b0, 3'($urandom_range(1, 7)), 12'($urandom)};
		if (sel < 95)
			return 16'h8000;
		return 16'($urandom);
	endfunction

	// receiver stalls: phases of always ready, a repeating mask, and random stalls
	initial begin
		int          phase_left;
		int          mode;
		int          slot;
		logic [7:0]  mask;
		phase_left = 0;
		mode = 0;
		slot = 0;
		mask = 8'hff;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (draining) begin
				out_ready = 1'b1;
			end else begin
				if (phase_left == 0) begin
					phase_left = $urandom_range(16, 96);
					mode = $urandom_range(0, 2);
					mask = 8'($urandom_range(1, 255));
				end
				phase_left--;
				case (mode)
					0: begin
						out_ready = 1'b1;
					end
					1: begin
						out_ready = mask[slot];
						slot = (slot + 1) % 8;
					end
					default: begin
						out_ready = ($urandom_range(0, 3) != 0);
					end
				endcase
			end
		end
	end

	// output transactions
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_sample(sample_value, decode_error, last_of_word);
	end

	// stimulus
	initial begin
		logic [udsd_pkg::WORD_W-1:0] dir_words [0:19];
		bit                          dir_first [0:19];
		logic [udsd_pkg::WORD_W-1:0] w;
		logic                        f;
		int                          counted;
		dir_words = '{16'h0000, 16'h0fff, 16'hffff, 16'h0000, 16'ha081,
			16'h0ffe, 16'hb221, 16'h8000, 16'hc000, 16'h8203,
			16'h0123, 16'hffff, 16'h0456, 16'h8001, 16'h8000,
			16'h1000, 16'h0fff, 16'h7fff, 16'hffff, 16'hb221};
		dir_first = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 1, 0, 1, 0};
		counted = 0;
		arst_n = 1'b0;
		code_word = '0;
		first_of_channel = 1'b0;
		in_valid = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every difference, clamping, no marker, errors and halt
		for (int i = 0; i < 20; i++) begin
			pace_sender();
			send_word(dir_words[i], dir_first[i]);
		end
		wait_all_decoded();

		// random channels
		while (counted < RANDOM_WORDS) begin
			f = ($urandom_range(0, 99) < 6);
			if (board.halted && $urandom_range(0, 99) < 80)
				f = 1'b1;
			w = pick_word();
			if (!board.halted || f)
				counted++;
			pace_sender();
			send_word(w, f);
			if ($urandom_range(0, 59) == 0)
				wait_all_decoded();
		end

		// drain and let trailing results show up
		@(negedge clk);
		in_valid = 1'b0;
		draining = 1'b1;
		while (board.expected_samples.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected_samples.size() == 0)
			$display("tb_unary_delta_sample_decoder_top OK");
		else
			$display("tb_unary_delta_sample_decoder_top NOT OK");
		$finish;
	end

endmodule
